/* src/rm_pkg.sv */
// ---------------------------------------------------------------------------
// rm_pkg
// shared types and command codes for the running median sorted cell chains
// ---------------------------------------------------------------------------
package rm_pkg;

    localparam int DATA_W = 32;
    localparam int HELD_W = 11;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [1:0]               chain_op_t;

    // hold, sorted insert, push at head, drop head with sorted insert
    localparam chain_op_t OP_HOLD = 2'd0;
    localparam chain_op_t OP_INS  = 2'd1;
    localparam chain_op_t OP_PUSH = 2'd2;
    localparam chain_op_t OP_POP  = 2'd3;

    typedef struct packed {
        chain_op_t op;
        sample_t   x;
    } chain_cmd_t;

endpackage

/* src/rm_cell.sv */
// ---------------------------------------------------------------------------
// rm_cell
// one slot of an ascending sorted chain; takes from itself, its neighbors
// or the broadcast value on each command
// ---------------------------------------------------------------------------
module rm_cell (
    input  logic                aclk,
    input  rm_pkg::chain_cmd_t  cmd,
    input  rm_pkg::sample_t     left_val,
    input  rm_pkg::sample_t     right_val,
    input  logic                occ,
    input  logic                occ_right,
    input  logic                left_keep_ins,
    input  logic                left_keep_pop,
    output rm_pkg::sample_t     val,
    output logic                keep_ins,
    output logic                keep_pop
);

    rm_pkg::sample_t val_reg;
    rm_pkg::sample_t val_next;

    assign keep_ins = occ && (val_reg <= cmd.x) && (cmd.op == rm_pkg::OP_INS);
    assign keep_pop = occ_right && (right_val <= cmd.x);

    always_comb begin
        val_next = val_reg;
        unique case (cmd.op) inside
            rm_pkg::OP_HOLD: val_next = val_reg;
            rm_pkg::OP_INS, rm_pkg::OP_PUSH: begin
                if (keep_ins) begin
                    val_next = val_reg;
                end else if (left_keep_ins) begin
                    val_next = cmd.x;
                end else begin
                    val_next = left_val;
                end
            end
            rm_pkg::OP_POP: begin
                if (keep_pop) begin
                    val_next = right_val;
                end else if (left_keep_pop) begin
                    val_next = cmd.x;
                end else begin
                    val_next = val_reg;
                end
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

/* src/rm_chain.sv */
// ---------------------------------------------------------------------------
// rm_chain
// row of sorted cells, ascending from the head; occupancy follows the count
// ---------------------------------------------------------------------------
module rm_chain #(
    parameter int N  = 512,
    parameter int NW = 10
) (
    input  logic               aclk,
    input  rm_pkg::chain_cmd_t cmd,
    input  logic [NW-1:0]      n,
    output rm_pkg::sample_t    head
);

    rm_pkg::sample_t val   [0:N];
    logic            occ   [0:N];
    logic            k_ins [0:N];
    logic            k_pop [0:N];

    assign val[N]   = '0;
    assign occ[N]   = 1'b0;
    assign k_ins[0] = 1'b1;
    assign k_pop[0] = 1'b1;

    for (genvar i = 0; i < N; i++) begin : g_cell
        assign occ[i] = (NW'(i) < n);

        rm_cell u_cell (
            .aclk          (aclk),
            .cmd           (cmd),
            .left_val      ((i == 0) ? cmd.x : val[(i == 0) ? 0 : i-1]),
            .right_val     (val[i+1]),
            .occ           (occ[i]),
            .occ_right     (occ[i+1]),
            .left_keep_ins (k_ins[i]),
            .left_keep_pop (k_pop[i]),
            .val           (val[i]),
            .keep_ins      (k_ins[i+1]),
            .keep_pop      (k_pop[i+1])
        );
    end

    assign head = val[0];

endmodule

/* src/running_median.sv */
// ---------------------------------------------------------------------------
// running_median
// running median over a bounded sorted store kept as two cell chains
//
//   channel  dir  ports                                  beat
//   s_       in   s_valid s_ready s_sample               one sample
//   m_       out  m_valid m_ready m_median m_held_count  one result per sample
//                 m_dropped
//
// each beat has an insert step that updates both chains in place, then a
// readout step that forms the median from the two chain heads
// the readout waits while the result register is held by m_ready low
// reset clears the count and the handshake state only; no clearing pass
// a sample that arrives with the store full is dropped and flagged
// ---------------------------------------------------------------------------
module running_median #(
    parameter int CAPACITY = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [rm_pkg::DATA_W-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [rm_pkg::DATA_W-1:0] m_median,
    output logic [rm_pkg::HELD_W-1:0]     m_held_count,
    output logic                          m_dropped
);

    localparam int LN = (CAPACITY + 1) / 2;
    localparam int UN = CAPACITY / 2;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = $clog2(LN + 1);
    localparam int UW = $clog2(UN + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                 state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 drop_reg, drop_next;
    logic                 m_valid_reg, m_valid_next;
    rm_pkg::sample_t      m_median_reg, m_median_next;
    logic [rm_pkg::HELD_W-1:0] m_held_reg, m_held_next;
    logic                 m_dropped_reg, m_dropped_next;

    logic [CW:0]          count_inc;
    logic [LW-1:0]        n_lower;
    logic [UW-1:0]        n_upper;
    rm_pkg::sample_t      lower_head, upper_head, l0;
    rm_pkg::chain_cmd_t   lower_cmd, upper_cmd;
    logic                 accept, full, odd;
    logic signed [rm_pkg::DATA_W:0] pair_sum, pair_half;
    rm_pkg::sample_t      med;
    logic [CW+rm_pkg::HELD_W-1:0] held_wide;

    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign odd       = count_reg[0];
    assign count_inc = {1'b0, count_reg} + {{CW{1'b0}}, 1'b1};
    assign n_lower   = LW'(count_inc >> 1);
    assign n_upper   = UW'(count_reg >> 1);
    assign l0        = ~lower_head;

    always_comb begin
        lower_cmd.op = rm_pkg::OP_HOLD;
        lower_cmd.x  = ~s_sample;
        upper_cmd.op = rm_pkg::OP_HOLD;
        upper_cmd.x  = s_sample;
        if (accept && !full) begin
            if (!odd) begin
                if ((count_reg != '0) && (s_sample > upper_head)) begin
                    upper_cmd.op = rm_pkg::OP_POP;
                    lower_cmd.op = rm_pkg::OP_PUSH;
                    lower_cmd.x  = ~upper_head;
                end else begin
                    lower_cmd.op = rm_pkg::OP_INS;
                end
            end else begin
                if (s_sample >= l0) begin
                    upper_cmd.op = rm_pkg::OP_INS;
                end else begin
                    lower_cmd.op = rm_pkg::OP_POP;
                    upper_cmd.op = rm_pkg::OP_PUSH;
                    upper_cmd.x  = l0;
                end
            end
        end
    end

    rm_chain #(.N(LN), .NW(LW)) u_lower (
        .aclk (aclk),
        .cmd  (lower_cmd),
        .n    (n_lower),
        .head (lower_head)
    );

    rm_chain #(.N(UN), .NW(UW)) u_upper (
        .aclk (aclk),
        .cmd  (upper_cmd),
        .n    (n_upper),
        .head (upper_head)
    );

    // even count: halve the wide pair sum, rounding toward zero
    assign pair_sum  = {l0[rm_pkg::DATA_W-1], l0} + {upper_head[rm_pkg::DATA_W-1], upper_head};
    assign pair_half = pair_sum >>> 1;
    assign med = odd ? l0
                     : (pair_half[rm_pkg::DATA_W-1:0]
                        + rm_pkg::DATA_W'(pair_sum[rm_pkg::DATA_W] & pair_sum[0]));
    assign held_wide = {{rm_pkg::HELD_W{1'b0}}, count_reg};

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        m_valid_next   = m_valid_reg;
        m_median_next  = m_median_reg;
        m_held_next    = m_held_reg;
        m_dropped_next = m_dropped_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    drop_next  = full;
                    count_next = full ? count_reg : count_inc[CW-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_median_next  = med;
                    m_held_next    = held_wide[rm_pkg::HELD_W-1:0];
                    m_dropped_next = drop_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        drop_reg      <= drop_next;
        m_median_reg  <= m_median_next;
        m_held_reg    <= m_held_next;
        m_dropped_reg <= m_dropped_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_median     = m_median_reg;
    assign m_held_count = m_held_reg;
    assign m_dropped    = m_dropped_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("held count above capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !full) |=> (count_reg == $past(count_inc[CW-1:0])))
        else $error("count did not advance on insert");

    a_drop_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && full) |=> $stable(count_reg))
        else $error("count moved on dropped beat");

    a_heads_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IDLE) && (count_reg >= CW'(2))) |-> (l0 <= upper_head))
        else $error("lower head above upper head");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_dropped_reg) |-> (count_reg == CW'(CAPACITY)))
        else $error("drop flagged below capacity");

endmodule
